>>> src/fbds_pkg.sv
// Shared types, constants and ratio tables for the fractional baud divisor search.
`timescale 1ns / 1ps
`default_nettype none
package fbds_pkg;

   localparam int CLK_W             = 28;
   localparam int BAUD_W            = 23;
   localparam int DEN_W             = BAUD_W + 4;
   localparam int DV_W              = 24;
   localparam int K_W               = 10;
   localparam int DIVISOR_W         = 16;
   localparam int ROM_SIZE          = 72;
   localparam int RATIO_ENTRIES_DEF = 72;
   localparam int FRAC_BITS_DEF     = 16;
   localparam int LOW_LIMIT_MILLI   = 1100;
   localparam int HIGH_LIMIT_MILLI  = 1900;

   localparam logic [CLK_W-1:0]     CLK_RESET   = 28'd60000000;
   localparam logic [K_W-1:0]       THOUSAND    = 10'd1000;
   localparam logic [DIVISOR_W-1:0] DIVISOR_MAX = 16'hFFFF;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_RATIO = 2'd1;
   localparam logic [1:0] ST_TOO_BIG  = 2'd2;

   typedef enum logic [2:0] {
      OP_MUL_RATIO,
      OP_MUL_DV,
      OP_MUL_K,
      OP_DIV_WIDE,
      OP_DIV_NARROW
   } fbds_op_type;

   typedef struct packed {
      logic        start;
      fbds_op_type op;
   } fbds_cmd_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [DIVISOR_W-1:0] divisor;
      logic [3:0]           div_add;
      logic [3:0]           mul_val;
   } fbds_result_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INT_DIV,
      S_K_MUL,
      S_LAUNCH,
      S_R_MUL,
      S_DV_DIV,
      S_P_MUL,
      S_RE_DIV,
      S_SCAN,
      S_DONE
   } fbds_state_type;

   // ratios 1 + add/mul in thousandths
   localparam logic [10:0] RATIO_MILLI [ROM_SIZE] = '{
      11'd1000, 11'd1067, 11'd1071, 11'd1077, 11'd1083, 11'd1091, 11'd1100, 11'd1111,
      11'd1125, 11'd1133, 11'd1143, 11'd1154, 11'd1167, 11'd1182, 11'd1200, 11'd1214,
      11'd1222, 11'd1231, 11'd1250, 11'd1267, 11'd1273, 11'd1286, 11'd1300, 11'd1308,
      11'd1333, 11'd1357, 11'd1364, 11'd1375, 11'd1385, 11'd1400, 11'd1417, 11'd1429,
      11'd1444, 11'd1455, 11'd1462, 11'd1467, 11'd1500, 11'd1533, 11'd1538, 11'd1545,
      11'd1556, 11'd1571, 11'd1583, 11'd1600, 11'd1615, 11'd1625, 11'd1636, 11'd1643,
      11'd1667, 11'd1692, 11'd1700, 11'd1714, 11'd1727, 11'd1733, 11'd1750, 11'd1769,
      11'd1778, 11'd1786, 11'd1800, 11'd1818, 11'd1833, 11'd1846, 11'd1857, 11'd1867,
      11'd1875, 11'd1889, 11'd1900, 11'd1909, 11'd1917, 11'd1923, 11'd1929, 11'd1933
   };

   localparam logic [3:0] ADD_ROM [ROM_SIZE] = '{
      4'd0,  4'd1,  4'd1,  4'd1,  4'd1,  4'd1,  4'd1,  4'd1,  4'd1,  4'd2,  4'd1,  4'd2,
      4'd1,  4'd2,  4'd1,  4'd3,  4'd2,  4'd3,  4'd1,  4'd4,  4'd3,  4'd2,  4'd3,  4'd4,
      4'd1,  4'd5,  4'd4,  4'd3,  4'd5,  4'd2,  4'd5,  4'd3,  4'd4,  4'd5,  4'd6,  4'd7,
      4'd1,  4'd8,  4'd7,  4'd6,  4'd5,  4'd4,  4'd7,  4'd3,  4'd8,  4'd5,  4'd7,  4'd9,
      4'd2,  4'd9,  4'd7,  4'd5,  4'd8,  4'd11, 4'd3,  4'd10, 4'd7,  4'd11, 4'd4,  4'd9,
      4'd5,  4'd11, 4'd6,  4'd13, 4'd7,  4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14
   };

   localparam logic [3:0] MUL_ROM [ROM_SIZE] = '{
      4'd1,  4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9,  4'd8,  4'd15, 4'd7,  4'd13,
      4'd6,  4'd11, 4'd5,  4'd14, 4'd9,  4'd13, 4'd4,  4'd15, 4'd11, 4'd7,  4'd10, 4'd13,
      4'd3,  4'd14, 4'd11, 4'd8,  4'd13, 4'd5,  4'd12, 4'd7,  4'd9,  4'd11, 4'd13, 4'd15,
      4'd2,  4'd15, 4'd13, 4'd11, 4'd9,  4'd7,  4'd12, 4'd5,  4'd13, 4'd8,  4'd11, 4'd14,
      4'd3,  4'd13, 4'd10, 4'd7,  4'd11, 4'd15, 4'd4,  4'd13, 4'd9,  4'd14, 4'd5,  4'd11,
      4'd6,  4'd13, 4'd7,  4'd15, 4'd8,  4'd9,  4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
   };

endpackage
`default_nettype wire

>>> src/fbds_unit.sv
// Shared bit-serial unit: shift-add multiply and restoring divide, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module fbds_unit #(
   parameter int  FRAC_BITS = fbds_pkg::FRAC_BITS_DEF,
   localparam int FIX_W     = FRAC_BITS + 2,
   localparam int NUM_W     = fbds_pkg::CLK_W + FRAC_BITS,
   localparam int SW        = (FIX_W > fbds_pkg::DV_W) ? FIX_W : fbds_pkg::DV_W,
   localparam int PROD_W    = fbds_pkg::DEN_W +
                              ((FRAC_BITS + 1 > fbds_pkg::DV_W) ? FRAC_BITS + 1
                                                                : fbds_pkg::DV_W)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  fbds_pkg::fbds_cmd_type       cmd,
   input  logic [NUM_W-1:0]             dividend,
   input  logic [PROD_W-1:0]            divisor,
   input  logic [fbds_pkg::DEN_W-1:0]   mcand,
   input  logic [SW-1:0]                mplr,
   output logic                         done,
   output logic [PROD_W-1:0]            acc,
   output logic [SW-1:0]                quo
);
   import fbds_pkg::*;

   localparam int QD    = DV_W;
   localparam int QR    = FIX_W;
   localparam int CNT_W = $clog2(SW + 1);
   localparam int SUM_W = PROD_W + 2;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   fbds_op_type       op_ff;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [PROD_W-1:0] b_ff;
   logic [SW-1:0]     sh_ff, sh_in;

   logic              is_div;
   logic              top_bit;
   logic [PROD_W:0]   op_a, op_b;
   logic [SUM_W-1:0]  sum;
   logic              ge;
   logic [PROD_W-1:0] load_acc, load_b;
   logic [SW-1:0]     load_sh;
   logic [CNT_W-1:0]  load_cnt;
   logic              last_step;

   // one add/sub shared by both operations
   always_comb begin
      top_bit = sh_ff[SW-1];
      is_div  = (op_ff == OP_DIV_WIDE) || (op_ff == OP_DIV_NARROW);
      op_a    = {acc_ff, is_div ? top_bit : 1'b0};
      if (is_div) begin
         op_b = ~{1'b0, b_ff};
      end else if (top_bit) begin
         op_b = {1'b0, b_ff};
      end else begin
         op_b = '0;
      end
      sum = {1'b0, op_a} + {1'b0, op_b} + SUM_W'(is_div);
      ge  = sum[SUM_W-1];
   end

   always_comb begin
      load_acc = '0;
      load_b   = PROD_W'(mcand);
      load_sh  = '0;
      load_cnt = CNT_W'(1);
      case (cmd.op)
         OP_DIV_WIDE: begin
            load_acc = PROD_W'(dividend >> QD);
            load_sh  = SW'(dividend[QD-1:0]) << (SW - QD);
            load_cnt = CNT_W'(QD);
            load_b   = divisor;
         end
         OP_DIV_NARROW: begin
            load_acc = PROD_W'(dividend >> QR);
            load_sh  = SW'(dividend[QR-1:0]) << (SW - QR);
            load_cnt = CNT_W'(QR);
            load_b   = divisor;
         end
         OP_MUL_RATIO: begin
            load_sh  = SW'(mplr[FIX_W-1:0]) << (SW - FIX_W);
            load_cnt = CNT_W'(FIX_W);
         end
         OP_MUL_DV: begin
            load_sh  = SW'(mplr[DV_W-1:0]) << (SW - DV_W);
            load_cnt = CNT_W'(DV_W);
         end
         OP_MUL_K: begin
            load_sh  = SW'(mplr[K_W-1:0]) << (SW - K_W);
            load_cnt = CNT_W'(K_W);
         end
         default: begin
            load_cnt = CNT_W'(1);
         end
      endcase
   end

   always_comb begin
      last_step = busy_ff && (cnt_ff == CNT_W'(1));
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      sh_in     = sh_ff;
      done_in   = last_step;
      if (!busy_ff && cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = load_cnt;
         acc_in  = load_acc;
         sh_in   = load_sh;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CNT_W'(1);
         if (last_step) begin
            busy_in = 1'b0;
         end
         if (is_div) begin
            acc_in = ge ? sum[PROD_W-1:0] : op_a[PROD_W-1:0];
            sh_in  = {sh_ff[SW-2:0], ge};
         end else begin
            acc_in = sum[PROD_W-1:0];
            sh_in  = {sh_ff[SW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      if (!busy_ff && cmd.start) begin
         op_ff <= cmd.op;
         b_ff  <= load_b;
      end
   end

   assign done = done_ff;
   assign acc  = acc_ff;
   assign quo  = sh_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("unit started while busy");

   a_done_free: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("unit done while still busy");

endmodule
`default_nettype wire

>>> src/fbds_seq.sv
// Sequencer: integer test, ratio table walk and nearest-ratio scan over the shared unit.
`timescale 1ns / 1ps
`default_nettype none
module fbds_seq #(
   parameter int  RATIO_ENTRIES = fbds_pkg::RATIO_ENTRIES_DEF,
   parameter int  FRAC_BITS     = fbds_pkg::FRAC_BITS_DEF,
   localparam int FIX_W         = FRAC_BITS + 2,
   localparam int NUM_W         = fbds_pkg::CLK_W + FRAC_BITS,
   localparam int SW            = (FIX_W > fbds_pkg::DV_W) ? FIX_W : fbds_pkg::DV_W,
   localparam int PROD_W        = fbds_pkg::DEN_W +
                                  ((FRAC_BITS + 1 > fbds_pkg::DV_W) ? FRAC_BITS + 1
                                                                    : fbds_pkg::DV_W)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fbds_pkg::BAUD_W-1:0]    baud_rate,
   input  logic [fbds_pkg::CLK_W-1:0]     clk_hz,
   input  logic                           out_free,
   output logic                           idle,
   output logic                           res_valid,
   output fbds_pkg::fbds_result_type      res,
   output fbds_pkg::fbds_cmd_type         cmd,
   output logic [NUM_W-1:0]               dividend,
   output logic [PROD_W-1:0]              divisor,
   output logic [fbds_pkg::DEN_W-1:0]     mcand,
   output logic [SW-1:0]                  mplr,
   input  logic                           done,
   input  logic [PROD_W-1:0]              acc,
   input  logic [SW-1:0]                  quo
);
   import fbds_pkg::*;

   localparam int N_USE = (RATIO_ENTRIES < ROM_SIZE) ? RATIO_ENTRIES : ROM_SIZE;
   localparam int IDX_W = $clog2(N_USE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_USE - 1);
   localparam logic [63:0] LOW_M  = 64'(LOW_LIMIT_MILLI);
   localparam logic [63:0] HIGH_M = 64'(HIGH_LIMIT_MILLI);
   localparam logic [FIX_W-1:0] LOW_FIX  =
      FIX_W'(((LOW_M << FRAC_BITS) + 64'd500) / 64'd1000);
   localparam logic [FIX_W-1:0] HIGH_FIX =
      FIX_W'(((HIGH_M << FRAC_BITS) + 64'd500) / 64'd1000);

   logic [FIX_W-1:0] ratio_fix [N_USE];

   for (genvar g = 0; g < N_USE; g++) begin : g_fix
      localparam logic [63:0] MILLI = 64'(RATIO_MILLI[g]);
      localparam logic [FIX_W-1:0] FIX_VAL =
         FIX_W'(((MILLI << FRAC_BITS) + 64'd500) / 64'd1000);
      assign ratio_fix[g] = FIX_VAL;
   end

   fbds_state_type   state_ff, state_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DV_W-1:0]  ival_ff, ival_in;
   logic [DV_W-1:0]  dv_ff, dv_in;
   logic [FIX_W-1:0] real_ff, real_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   fbds_result_type  res_ff, res_in;

   logic [DEN_W-1:0] den_req;
   logic [NUM_W-1:0] num;
   logic [FIX_W-1:0] real_q;
   logic [FIX_W-1:0] lo, hi;
   logic [IDX_W-1:0] idx_inc, hi_idx, pick_idx;
   logic             last_entry, in_bracket, lower_nearer;
   fbds_result_type  fail_res, int_res, pick_res;

   always_comb begin
      den_req      = {baud_rate, 4'b0000};
      num          = NUM_W'(clk_hz) << FRAC_BITS;
      real_q       = quo[FIX_W-1:0];
      last_entry   = (idx_ff == LAST_IDX);
      idx_inc      = idx_ff + IDX_W'(1);
      hi_idx       = last_entry ? idx_ff : idx_inc;
      lo           = ratio_fix[idx_ff];
      hi           = ratio_fix[hi_idx];
      in_bracket   = (real_ff >= lo) && (real_ff <= hi);
      lower_nearer = (real_ff - lo) <= (hi - real_ff);
      pick_idx     = (last_entry || lower_nearer) ? idx_ff : idx_inc;

      fail_res = '{status: ST_NO_RATIO, divisor: '0, div_add: 4'd0, mul_val: 4'd1};

      int_res.div_add = 4'd0;
      int_res.mul_val = 4'd1;
      if (ival_ff[DV_W-1:DIVISOR_W] != '0) begin
         int_res.status  = ST_TOO_BIG;
         int_res.divisor = DIVISOR_MAX;
      end else begin
         int_res.status  = ST_OK;
         int_res.divisor = ival_ff[DIVISOR_W-1:0];
      end

      pick_res.div_add = ADD_ROM[pick_idx];
      pick_res.mul_val = MUL_ROM[pick_idx];
      if (dv_ff[DV_W-1:DIVISOR_W] != '0) begin
         pick_res.status  = ST_TOO_BIG;
         pick_res.divisor = DIVISOR_MAX;
      end else begin
         pick_res.status  = ST_OK;
         pick_res.divisor = dv_ff[DIVISOR_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      den_in    = den_ff;
      ival_in   = ival_ff;
      dv_in     = dv_ff;
      real_in   = real_ff;
      idx_in    = idx_ff;
      res_in    = res_ff;
      idle      = 1'b0;
      res_valid = 1'b0;
      cmd       = '{start: 1'b0, op: OP_MUL_K};
      dividend  = num;
      divisor   = acc;
      mcand     = den_ff;
      mplr      = quo;
      case (state_ff)
         S_IDLE: begin
            idle = 1'b1;
            if (start) begin
               den_in = den_req;
               if (baud_rate == '0) begin
                  res_in   = fail_res;
                  state_in = S_DONE;
               end else begin
                  cmd      = '{start: 1'b1, op: OP_DIV_WIDE};
                  dividend = NUM_W'(clk_hz);
                  divisor  = PROD_W'(den_req);
                  state_in = S_INT_DIV;
               end
            end
         end
         S_INT_DIV: begin
            if (done) begin
               ival_in  = quo[DV_W-1:0];
               cmd      = '{start: 1'b1, op: OP_MUL_K};
               mcand    = acc[DEN_W-1:0];
               mplr     = SW'(THOUSAND);
               state_in = S_K_MUL;
            end
         end
         S_K_MUL: begin
            // integer path when the first three decimals are zero
            if (done) begin
               if ((ival_ff != '0) && (acc < PROD_W'(den_ff))) begin
                  res_in   = int_res;
                  state_in = S_DONE;
               end else begin
                  idx_in   = '0;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_LAUNCH: begin
            cmd      = '{start: 1'b1, op: OP_MUL_RATIO};
            mplr     = SW'(ratio_fix[idx_ff]);
            state_in = S_R_MUL;
         end
         S_R_MUL: begin
            if (done) begin
               cmd      = '{start: 1'b1, op: OP_DIV_WIDE};
               state_in = S_DV_DIV;
            end
         end
         S_DV_DIV: begin
            if (done) begin
               if (quo == '0) begin
                  if (last_entry) begin
                     res_in   = fail_res;
                     state_in = S_DONE;
                  end else begin
                     idx_in   = idx_inc;
                     state_in = S_LAUNCH;
                  end
               end else begin
                  dv_in    = quo[DV_W-1:0];
                  cmd      = '{start: 1'b1, op: OP_MUL_DV};
                  state_in = S_P_MUL;
               end
            end
         end
         S_P_MUL: begin
            if (done) begin
               cmd      = '{start: 1'b1, op: OP_DIV_NARROW};
               state_in = S_RE_DIV;
            end
         end
         S_RE_DIV: begin
            if (done) begin
               if ((real_q > LOW_FIX) && (real_q < HIGH_FIX)) begin
                  real_in  = real_q;
                  idx_in   = '0;
                  state_in = S_SCAN;
               end else if (last_entry) begin
                  res_in   = fail_res;
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_inc;
                  state_in = S_LAUNCH;
               end
            end
         end
         S_SCAN: begin
            if (last_entry || in_bracket) begin
               res_in   = pick_res;
               state_in = S_DONE;
            end else begin
               idx_in = idx_inc;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff  <= den_in;
      ival_ff <= ival_in;
      dv_ff   <= dv_in;
      real_ff <= real_in;
      idx_ff  <= idx_in;
      res_ff  <= res_in;
   end

   assign res = res_ff;

   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ((real_ff > LOW_FIX) && (real_ff < HIGH_FIX)))
      else $error("scan entered with ratio outside limits");

   a_res_mul: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> ((res_ff.mul_val != 4'd0) && (res_ff.status != 2'd3)))
      else $error("bad result word");

endmodule
`default_nettype wire

>>> src/fractional_baud_divisor_search.sv
// Top level: clock register, request/response handshake and output register.
//
// Usage: write the peripheral clock in hertz on csr_write_data with csr_write_enable
// (reset value 60 MHz) while the block is idle. Present a baud rate on req_baud_rate
// with req_valid; the word is taken on a clock edge where req_stall is low. One
// response word (status, divisor, div_add, mul_val) follows on the rsp_ channel.
// Only one request is in flight: req_stall stays high from acceptance until the
// result has been loaded into the output register.
// The integer test is a wide divide and a multiply by 1000 on the bit-serial unit;
// when the clock divides to an integer, its quotient is the answer. Otherwise each
// table entry walked costs four serial operations (ratio multiply, wide divide,
// multiply, narrow divide), or two when its divisor is zero; the first entry whose
// ratio lands within the limits starts the one-entry-per-cycle nearest-ratio scan.
// A zero baud rate, or a table that runs out, gives the no-ratio status.
// A new request is taken only after the previous result is in the output register.
// If rsp_stall holds the output word, the next result waits in the sequencer and
// the block accepts nothing further until the output register frees up.
// Synchronous reset clears the handshake state and restores the clock register.
`timescale 1ns / 1ps
`default_nettype none
module fractional_baud_divisor_search #(
   parameter int RATIO_ENTRIES = fbds_pkg::RATIO_ENTRIES_DEF,
   parameter int FRAC_BITS     = fbds_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [fbds_pkg::CLK_W-1:0]        csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [fbds_pkg::BAUD_W-1:0]       req_baud_rate,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [fbds_pkg::DIVISOR_W-1:0]    rsp_divisor,
   output logic [3:0]                        rsp_div_add,
   output logic [3:0]                        rsp_mul_val
);
   import fbds_pkg::*;

   localparam int FIX_W  = FRAC_BITS + 2;
   localparam int NUM_W  = CLK_W + FRAC_BITS;
   localparam int SW     = (FIX_W > DV_W) ? FIX_W : DV_W;
   localparam int PROD_W = DEN_W + ((FRAC_BITS + 1 > DV_W) ? FRAC_BITS + 1 : DV_W);

   logic [CLK_W-1:0] clk_hz_ff, clk_hz_in;
   logic             rsp_valid_ff, rsp_valid_in;
   fbds_result_type  rsp_ff, rsp_in;

   logic              seq_idle, res_valid, out_free, start;
   fbds_result_type   res;
   fbds_cmd_type      cmd;
   logic [NUM_W-1:0]  dividend;
   logic [PROD_W-1:0] divisor, acc;
   logic [DEN_W-1:0]  mcand;
   logic [SW-1:0]     mplr, quo;
   logic              done;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !seq_idle;
   assign start     = req_valid && seq_idle;

   always_comb begin
      clk_hz_in    = csr_write_enable ? csr_write_data : clk_hz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff    <= CLK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clk_hz_ff    <= clk_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   fbds_seq #(
      .RATIO_ENTRIES (RATIO_ENTRIES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .baud_rate (req_baud_rate),
      .clk_hz    (clk_hz_ff),
      .out_free  (out_free),
      .idle      (seq_idle),
      .res_valid (res_valid),
      .res       (res),
      .cmd       (cmd),
      .dividend  (dividend),
      .divisor   (divisor),
      .mcand     (mcand),
      .mplr      (mplr),
      .done      (done),
      .acc       (acc),
      .quo       (quo)
   );

   fbds_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .dividend (dividend),
      .divisor  (divisor),
      .mcand    (mcand),
      .mplr     (mplr),
      .done     (done),
      .acc      (acc),
      .quo      (quo)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_ff.status;
   assign rsp_divisor = rsp_ff.divisor;
   assign rsp_div_add = rsp_ff.div_add;
   assign rsp_mul_val = rsp_ff.mul_val;

endmodule
`default_nettype wire
